// ----- hdl/dvrt_pkg.sv -----
package dvrt_pkg;

    localparam int NODES_DEF = 64;
    localparam int PORTS_DEF = 16;

    localparam int ID_W    = 6;
    localparam int COST_W  = 16;
    localparam int TIME_W  = 32;
    localparam int PORT_W  = 4;
    localparam int STAT_W  = 4;
    localparam int OP_W    = 3;
    localparam int CNT_W   = 7;

    localparam logic [OP_W-1:0] OP_REPLY   = 3'd0;
    localparam logic [OP_W-1:0] OP_ENTRY   = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
    localparam logic [OP_W-1:0] OP_FORWARD = 3'd3;
    localparam logic [OP_W-1:0] OP_ADVERT  = 3'd4;
    localparam logic [OP_W-1:0] OP_SPARE5  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6  = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7  = 3'd7;

    localparam logic [STAT_W-1:0] ST_REPLY_DONE  = 4'd0;
    localparam logic [STAT_W-1:0] ST_ENTRY_DONE  = 4'd1;
    localparam logic [STAT_W-1:0] ST_MISADDR     = 4'd2;
    localparam logic [STAT_W-1:0] ST_TICK_DONE   = 4'd3;
    localparam logic [STAT_W-1:0] ST_LOCAL       = 4'd4;
    localparam logic [STAT_W-1:0] ST_FORWARD     = 4'd5;
    localparam logic [STAT_W-1:0] ST_UNREACHABLE = 4'd6;
    localparam logic [STAT_W-1:0] ST_NO_PORT     = 4'd7;
    localparam logic [STAT_W-1:0] ST_ADV_ENTRY   = 4'd8;
    localparam logic [STAT_W-1:0] ST_ADV_EMPTY   = 4'd9;

    localparam logic [1:0] REG_OWN_ID   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_INFINITY = 2'd2;

    localparam logic [ID_W-1:0]   OWN_ID_RST   = 6'd0;
    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd15000;
    localparam logic [COST_W-1:0] INFINITY_RST = 16'hFFFF;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PORT_W-1:0] out_port;
        logic [ID_W-1:0]   dest_id;
        logic [COST_W-1:0] route_cost;
        logic [CNT_W-1:0]  expired_count;
        logic              last;
    } t_result;

endpackage

// ----- hdl/dvrt_if.sv -----
interface dvrt_in_if;
    logic                        valid;
    logic                        ready;
    logic [dvrt_pkg::OP_W-1:0]   op;
    logic [dvrt_pkg::ID_W-1:0]   nbr_id;
    logic [dvrt_pkg::ID_W-1:0]   node_id;
    logic [dvrt_pkg::COST_W-1:0] adv_cost;
    logic [dvrt_pkg::PORT_W-1:0] in_port;
    logic [dvrt_pkg::TIME_W-1:0] echo_ms;
    logic [dvrt_pkg::TIME_W-1:0] now_ms;
    logic [dvrt_pkg::ID_W-1:0]   addressed_to;

    modport source (output valid, op, nbr_id, node_id, adv_cost, in_port,
                    echo_ms, now_ms, addressed_to, input ready);
    modport sink (input valid, op, nbr_id, node_id, adv_cost, in_port,
                  echo_ms, now_ms, addressed_to, output ready);
endinterface

interface dvrt_out_if;
    logic                        valid;
    logic                        ready;
    logic [dvrt_pkg::STAT_W-1:0] status;
    logic [dvrt_pkg::PORT_W-1:0] out_port;
    logic [dvrt_pkg::ID_W-1:0]   dest_id;
    logic [dvrt_pkg::COST_W-1:0] route_cost;
    logic [dvrt_pkg::CNT_W-1:0]  expired_count;
    logic                        last;

    modport source (output valid, status, out_port, dest_id, route_cost,
                    expired_count, last, input ready);
    modport sink (input valid, status, out_port, dest_id, route_cost,
                  expired_count, last, output ready);
endinterface

// ----- hdl/dvrt_ram.sv -----
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- hdl/distance_vector_route_table_unit.sv -----
// Distance-vector route table engine.
// Requests arrive on i_req (valid/ready); each accepted beat is one operation.
// Results leave on o_rsp (valid/ready); every operation but unused op codes
// gives one result with last set, an advertisement gives one result per
// reachable-or-poisoned destination, or one empty result if there is none,
// and sets last on the final one. The route table and the neighbor table sit
// in two RAMs with registered read data; valid, heard and port bits are
// flip-flops cleared by reset. A reply that lowers the cost to the replying
// neighbor also shifts the routes whose next hop is that neighbor. A timeout
// tick sweeps the neighbor RAM and then the route RAM. An advertisement
// scans every entry and reads the route RAM only for valid entries other
// than the own node.
// One operation is worked on at a time; i_req.ready is high while idle. A
// single output register holds the next result; when the receiver stalls an
// advertisement scan waits for it, and a new request may be accepted while the
// last result of the previous one is still waiting. After reset all routes and
// neighbors are absent; no clearing pass is run. The user must write
// configuration over the APB port only while idle; the block does not check.
module distance_vector_route_table_unit #(
    parameter int NODES = dvrt_pkg::NODES_DEF,
    parameter int PORTS = dvrt_pkg::PORTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dvrt_in_if.sink     i_req,
    dvrt_out_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam logic [CW-1:0] IdxEnd = CW'(NODES);
    localparam logic [6:0] NodesW = 7'(NODES);
    localparam logic [8:0] PortsW = 9'(PORTS);
    localparam int RTW = dvrt_pkg::COST_W + dvrt_pkg::ID_W;
    localparam int NBW = dvrt_pkg::TIME_W + dvrt_pkg::PORT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_REPLY_CHK, S_SHIFT, S_ENTRY_A, S_ENTRY_B, S_TICK_NBR,
        S_TICK_RT, S_FWD_A, S_FWD_B, S_ADV_SCAN, S_ADV_DATA, S_FINISH
    } t_state;

    t_state r_state, n_state;

    logic [dvrt_pkg::ID_W-1:0]   r_own;
    logic [dvrt_pkg::TIME_W-1:0] r_timeout;
    logic [dvrt_pkg::COST_W-1:0] r_inf;

    logic [NODES-1:0] r_rvalid, n_rvalid;
    logic [NODES-1:0] r_heard, n_heard;
    logic [NODES-1:0] r_hasport, n_hasport;
    logic [NODES-1:0] r_expired, n_expired;
    logic             r_out_v, n_out_v;
    logic             r_pend_v, n_pend_v;
    logic             r_rd_v, n_rd_v;

    logic [dvrt_pkg::ID_W-1:0]   r_nb, n_nb;
    logic [dvrt_pkg::ID_W-1:0]   r_node, n_node;
    logic [dvrt_pkg::COST_W-1:0] r_cost, n_cost;
    logic [dvrt_pkg::PORT_W-1:0] r_port, n_port;
    logic [dvrt_pkg::TIME_W-1:0] r_now, n_now;
    logic [dvrt_pkg::COST_W-1:0] r_rtt, n_rtt;
    logic [dvrt_pkg::COST_W-1:0] r_old, n_old;
    logic [dvrt_pkg::COST_W-1:0] r_total, n_total;
    logic [CW-1:0]               r_idx, n_idx;
    logic [NW-1:0]               r_rd_idx, n_rd_idx;
    logic [dvrt_pkg::CNT_W-1:0]  r_count, n_count;
    logic [dvrt_pkg::ID_W-1:0]   r_pend_dest, n_pend_dest;
    logic [dvrt_pkg::COST_W-1:0] r_pend_cost, n_pend_cost;
    dvrt_pkg::t_result           r_res, n_res;
    dvrt_pkg::t_result           r_out, n_out;

    logic            rt_wr_en, rt_rd_en, nb_wr_en, nb_rd_en;
    logic [NW-1:0]   rt_wr_addr, rt_rd_addr, nb_wr_addr, nb_rd_addr;
    logic [RTW-1:0]  rt_wr_data, rt_rd_data;
    logic [NBW-1:0]  nb_wr_data, nb_rd_data;

    logic [dvrt_pkg::COST_W-1:0] rt_metric;
    logic [dvrt_pkg::ID_W-1:0]   rt_next;
    logic [dvrt_pkg::TIME_W-1:0] nb_time;
    logic [dvrt_pkg::PORT_W-1:0] nb_port;

    assign rt_metric = rt_rd_data[RTW-1:dvrt_pkg::ID_W];
    assign rt_next   = rt_rd_data[dvrt_pkg::ID_W-1:0];
    assign nb_time   = nb_rd_data[NBW-1:dvrt_pkg::PORT_W];
    assign nb_port   = nb_rd_data[dvrt_pkg::PORT_W-1:0];

    dvrt_ram #(.WIDTH(RTW), .DEPTH(NODES)) u_route_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rt_wr_en),
        .i_wr_addr (rt_wr_addr),
        .i_wr_data (rt_wr_data),
        .i_rd_en   (rt_rd_en),
        .i_rd_addr (rt_rd_addr),
        .o_rd_data (rt_rd_data)
    );

    dvrt_ram #(.WIDTH(NBW), .DEPTH(NODES)) u_nbr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (nb_wr_en),
        .i_wr_addr (nb_wr_addr),
        .i_wr_data (nb_wr_data),
        .i_rd_en   (nb_rd_en),
        .i_rd_addr (nb_rd_addr),
        .o_rd_data (nb_rd_data)
    );

    // Configuration port.
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            dvrt_pkg::REG_OWN_ID:   prdata = {26'd0, r_own};
            dvrt_pkg::REG_TIMEOUT:  prdata = r_timeout;
            dvrt_pkg::REG_INFINITY: prdata = {16'd0, r_inf};
            default:                prdata = 32'd0;
        endcase
    end

    // Request-side arithmetic.
    logic [dvrt_pkg::TIME_W-1:0] in_rtt_raw;
    logic [dvrt_pkg::COST_W-1:0] in_rtt;
    assign in_rtt_raw = i_req.now_ms - i_req.echo_ms;
    assign in_rtt = (in_rtt_raw > {16'd0, r_inf}) ? r_inf : in_rtt_raw[15:0];

    // Dependent shift of a route through the replying neighbor.
    logic [17:0]                 shift_sum;
    logic [dvrt_pkg::COST_W-1:0] shift_val;
    assign shift_sum = {2'b00, rt_metric} + {2'b00, r_rtt} - {2'b00, r_old};
    always_comb begin
        if (shift_sum[17]) begin
            shift_val = '0;
        end else if (shift_sum[16:0] > {1'b0, r_inf}) begin
            shift_val = r_inf;
        end else begin
            shift_val = shift_sum[15:0];
        end
    end

    // Relaxation cost of an advertised entry.
    logic [dvrt_pkg::COST_W-1:0] ent_ncost, ent_total;
    logic [16:0]                 ent_sum;
    always_comb begin
        if (r_nb == r_own) begin
            ent_ncost = '0;
        end else if (r_rvalid[r_nb[NW-1:0]]) begin
            ent_ncost = rt_metric;
        end else begin
            ent_ncost = r_inf;
        end
        ent_sum = {1'b0, r_cost} + {1'b0, ent_ncost};
        if (r_cost >= r_inf || ent_ncost >= r_inf) begin
            ent_total = r_inf;
        end else if (ent_sum > {1'b0, r_inf}) begin
            ent_total = r_inf;
        end else begin
            ent_total = ent_sum[15:0];
        end
    end

    logic out_free;
    logic [dvrt_pkg::TIME_W-1:0] silence;
    assign out_free = !r_out_v || o_rsp.ready;
    assign silence  = r_now - nb_time;

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_rvalid    = r_rvalid;
        n_heard     = r_heard;
        n_hasport   = r_hasport;
        n_expired   = r_expired;
        n_out_v     = r_out_v;
        n_pend_v    = r_pend_v;
        n_rd_v      = 1'b0;
        n_nb        = r_nb;
        n_node      = r_node;
        n_cost      = r_cost;
        n_port      = r_port;
        n_now       = r_now;
        n_rtt       = r_rtt;
        n_old       = r_old;
        n_total     = r_total;
        n_idx       = r_idx;
        n_rd_idx    = r_rd_idx;
        n_count     = r_count;
        n_pend_dest = r_pend_dest;
        n_pend_cost = r_pend_cost;
        n_res       = r_res;
        n_out       = r_out;
        rt_wr_en    = 1'b0;
        rt_wr_addr  = r_node[NW-1:0];
        rt_wr_data  = {r_total, r_nb};
        rt_rd_en    = 1'b0;
        rt_rd_addr  = r_nb[NW-1:0];
        nb_wr_en    = 1'b0;
        nb_wr_addr  = r_nb[NW-1:0];
        nb_wr_data  = {r_now, r_port};
        nb_rd_en    = 1'b0;
        nb_rd_addr  = r_nb[NW-1:0];

        if (r_out_v && o_rsp.ready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_nb   = i_req.nbr_id;
                    n_node = i_req.node_id;
                    n_cost = i_req.adv_cost;
                    n_port = i_req.in_port;
                    n_now  = i_req.now_ms;
                    n_rtt  = in_rtt;
                    n_res  = '0;
                    case (i_req.op)
                        dvrt_pkg::OP_REPLY: begin
                            n_res.status     = dvrt_pkg::ST_REPLY_DONE;
                            n_res.route_cost = in_rtt;
                            if ({1'b0, i_req.nbr_id} < NodesW) begin
                                rt_rd_en   = 1'b1;
                                rt_rd_addr = i_req.nbr_id[NW-1:0];
                                nb_rd_en   = 1'b1;
                                nb_rd_addr = i_req.nbr_id[NW-1:0];
                                n_state    = S_REPLY_CHK;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                        dvrt_pkg::OP_ENTRY: begin
                            if (i_req.addressed_to != r_own) begin
                                n_res.status = dvrt_pkg::ST_MISADDR;
                                n_state      = S_FINISH;
                            end else begin
                                n_res.status = dvrt_pkg::ST_ENTRY_DONE;
                                if ({1'b0, i_req.nbr_id} < NodesW &&
                                    {1'b0, i_req.node_id} < NodesW) begin
                                    rt_rd_en   = 1'b1;
                                    rt_rd_addr = i_req.nbr_id[NW-1:0];
                                    nb_rd_en   = 1'b1;
                                    nb_rd_addr = i_req.nbr_id[NW-1:0];
                                    n_state    = S_ENTRY_A;
                                end else begin
                                    n_state = S_FINISH;
                                end
                            end
                        end
                        dvrt_pkg::OP_TICK: begin
                            n_res.status = dvrt_pkg::ST_TICK_DONE;
                            n_idx        = '0;
                            n_count      = '0;
                            n_expired    = '0;
                            n_state      = S_TICK_NBR;
                        end
                        dvrt_pkg::OP_FORWARD: begin
                            if (i_req.node_id == r_own) begin
                                n_res.status = dvrt_pkg::ST_LOCAL;
                                n_state      = S_FINISH;
                            end else if ({1'b0, i_req.node_id} >= NodesW ||
                                         !r_rvalid[i_req.node_id[NW-1:0]]) begin
                                n_res.status = dvrt_pkg::ST_UNREACHABLE;
                                n_state      = S_FINISH;
                            end else begin
                                rt_rd_en   = 1'b1;
                                rt_rd_addr = i_req.node_id[NW-1:0];
                                n_state    = S_FWD_A;
                            end
                        end
                        dvrt_pkg::OP_ADVERT: begin
                            n_idx    = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_ADV_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_REPLY_CHK: begin
                n_heard[r_nb[NW-1:0]] = 1'b1;
                nb_wr_en = 1'b1;
                if ({5'd0, r_port} < PortsW) begin
                    n_hasport[r_nb[NW-1:0]] = 1'b1;
                    nb_wr_data = {r_now, r_port};
                end else begin
                    nb_wr_data = {r_now, nb_port};
                end
                rt_wr_addr = r_nb[NW-1:0];
                rt_wr_data = {r_rtt, r_nb};
                n_old      = rt_metric;
                n_idx      = '0;
                n_state    = S_FINISH;
                if (r_nb == r_own) begin
                    n_state = S_FINISH;
                end else if (!r_rvalid[r_nb[NW-1:0]]) begin
                    rt_wr_en = 1'b1;
                    n_rvalid[r_nb[NW-1:0]] = 1'b1;
                end else if (rt_metric >= r_inf || r_rtt < rt_metric) begin
                    rt_wr_en = 1'b1;
                    if (rt_metric < r_inf) begin
                        n_state = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                if (r_idx != IdxEnd) begin
                    rt_rd_en   = 1'b1;
                    rt_rd_addr = r_idx[NW-1:0];
                    n_idx      = r_idx + 1'b1;
                    n_rd_v     = 1'b1;
                    n_rd_idx   = r_idx[NW-1:0];
                end
                if (r_rd_v) begin
                    rt_wr_addr = r_rd_idx;
                    rt_wr_data = {shift_val, rt_next};
                    if (r_rvalid[r_rd_idx] && 7'(r_rd_idx) != {1'b0, r_nb} &&
                        7'(r_rd_idx) != {1'b0, r_own} && rt_next == r_nb &&
                        rt_metric < r_inf) begin
                        rt_wr_en = 1'b1;
                    end
                end else if (r_idx == IdxEnd) begin
                    n_state = S_FINISH;
                end
            end

            S_ENTRY_A: begin
                // Refresh liveness; the port field is written back unchanged.
                n_heard[r_nb[NW-1:0]] = 1'b1;
                nb_wr_en   = 1'b1;
                nb_wr_data = {r_now, nb_port};
                n_total    = ent_total;
                if (r_node == r_own) begin
                    n_state = S_FINISH;
                end else begin
                    rt_rd_en   = 1'b1;
                    rt_rd_addr = r_node[NW-1:0];
                    n_state    = S_ENTRY_B;
                end
            end

            S_ENTRY_B: begin
                rt_wr_addr = r_node[NW-1:0];
                rt_wr_data = {r_total, r_nb};
                if (!r_rvalid[r_node[NW-1:0]]) begin
                    rt_wr_en = 1'b1;
                    n_rvalid[r_node[NW-1:0]] = 1'b1;
                end else if (r_total >= r_inf && rt_next == r_nb) begin
                    rt_wr_en   = 1'b1;
                    rt_wr_data = {r_inf, r_nb};
                end else if (r_total < rt_metric) begin
                    rt_wr_en = 1'b1;
                end
                n_state = S_FINISH;
            end

            S_TICK_NBR: begin
                if (r_idx != IdxEnd) begin
                    nb_rd_en   = 1'b1;
                    nb_rd_addr = r_idx[NW-1:0];
                    n_idx      = r_idx + 1'b1;
                    n_rd_v     = 1'b1;
                    n_rd_idx   = r_idx[NW-1:0];
                end
                if (r_rd_v) begin
                    if (r_heard[r_rd_idx] && silence > r_timeout) begin
                        n_expired[r_rd_idx] = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end else if (r_idx == IdxEnd) begin
                    n_idx   = '0;
                    n_state = S_TICK_RT;
                end
            end

            S_TICK_RT: begin
                if (r_idx != IdxEnd) begin
                    rt_rd_en   = 1'b1;
                    rt_rd_addr = r_idx[NW-1:0];
                    n_idx      = r_idx + 1'b1;
                    n_rd_v     = 1'b1;
                    n_rd_idx   = r_idx[NW-1:0];
                end
                if (r_rd_v) begin
                    rt_wr_addr = r_rd_idx;
                    rt_wr_data = {r_inf, rt_next};
                    if (r_rvalid[r_rd_idx] && 7'(r_rd_idx) != {1'b0, r_own} &&
                        r_expired[rt_next[NW-1:0]]) begin
                        rt_wr_en = 1'b1;
                    end
                end else if (r_idx == IdxEnd) begin
                    n_heard   = r_heard & ~r_expired;
                    n_hasport = r_hasport & ~r_expired;
                    n_res.expired_count = r_count;
                    n_state   = S_FINISH;
                end
            end

            S_FWD_A: begin
                if (rt_metric >= r_inf) begin
                    n_res.status = dvrt_pkg::ST_UNREACHABLE;
                    n_state      = S_FINISH;
                end else if (!r_hasport[rt_next[NW-1:0]]) begin
                    n_res.status = dvrt_pkg::ST_NO_PORT;
                    n_state      = S_FINISH;
                end else begin
                    nb_rd_en   = 1'b1;
                    nb_rd_addr = rt_next[NW-1:0];
                    n_state    = S_FWD_B;
                end
            end

            S_FWD_B: begin
                n_res.status   = dvrt_pkg::ST_FORWARD;
                n_res.out_port = nb_port;
                n_state        = S_FINISH;
            end

            S_ADV_SCAN: begin
                if (r_idx == IdxEnd) begin
                    n_res = '0;
                    if (r_pend_v) begin
                        n_res.status     = dvrt_pkg::ST_ADV_ENTRY;
                        n_res.dest_id    = r_pend_dest;
                        n_res.route_cost = r_pend_cost;
                    end else begin
                        n_res.status = dvrt_pkg::ST_ADV_EMPTY;
                    end
                    n_pend_v = 1'b0;
                    n_state  = S_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (r_rvalid[r_idx[NW-1:0]] && 7'(r_idx) != {1'b0, r_own}) begin
                        rt_rd_en   = 1'b1;
                        rt_rd_addr = r_idx[NW-1:0];
                        n_rd_idx   = r_idx[NW-1:0];
                        n_state    = S_ADV_DATA;
                    end
                end
            end

            S_ADV_DATA: begin
                // The previous entry is sent only now that a later one exists,
                // so the final entry can carry last.
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out   = '0;
                        n_out.status     = dvrt_pkg::ST_ADV_ENTRY;
                        n_out.dest_id    = r_pend_dest;
                        n_out.route_cost = r_pend_cost;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_dest = 6'(r_rd_idx);
                    n_pend_cost = (rt_metric > r_inf) ? r_inf : rt_metric;
                    n_state     = S_ADV_SCAN;
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = r_res;
                    n_out.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rvalid  <= '0;
            r_heard   <= '0;
            r_hasport <= '0;
            r_expired <= '0;
            r_out_v   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_rd_v    <= 1'b0;
            r_own     <= dvrt_pkg::OWN_ID_RST;
            r_timeout <= dvrt_pkg::TIMEOUT_RST;
            r_inf     <= dvrt_pkg::INFINITY_RST;
        end else begin
            r_state   <= n_state;
            r_rvalid  <= n_rvalid;
            r_heard   <= n_heard;
            r_hasport <= n_hasport;
            r_expired <= n_expired;
            r_out_v   <= n_out_v;
            r_pend_v  <= n_pend_v;
            r_rd_v    <= n_rd_v;
            if (cfg_wr) begin
                case (paddr[3:2])
                    dvrt_pkg::REG_OWN_ID:   r_own     <= pwdata[5:0];
                    dvrt_pkg::REG_TIMEOUT:  r_timeout <= pwdata;
                    dvrt_pkg::REG_INFINITY: r_inf     <= pwdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nb        <= n_nb;
        r_node      <= n_node;
        r_cost      <= n_cost;
        r_port      <= n_port;
        r_now       <= n_now;
        r_rtt       <= n_rtt;
        r_old       <= n_old;
        r_total     <= n_total;
        r_idx       <= n_idx;
        r_rd_idx    <= n_rd_idx;
        r_count     <= n_count;
        r_pend_dest <= n_pend_dest;
        r_pend_cost <= n_pend_cost;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_rsp.valid         = r_out_v;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.out_port      = r_out.out_port;
    assign o_rsp.dest_id       = r_out.dest_id;
    assign o_rsp.route_cost    = r_out.route_cost;
    assign o_rsp.expired_count = r_out.expired_count;
    assign o_rsp.last          = r_out.last;
endmodule
